/* sv/gcs_pkg.sv */
`timescale 1ns / 1ps
// shared types, widths and constants of the great-circle scan
// no dependencies
package gcs_pkg;

  localparam int LatW  = 28;
  localparam int LonW  = 29;
  localparam int DistW = 25;
  localparam int NumW  = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int CW    = 36;   // cordic datapath width
  localparam int MW    = 33;   // multiplier operand width
  localparam int SqW   = 61;   // radicand width

  localparam logic [CfgIdxW-1:0] CFG_QUERY_LAT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUERY_LON = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS    = 2'd2;

  localparam int LAT_MAX = 90000000;
  localparam int LON_MAX = 180000000;
  localparam logic [30:0] CONV_Q56 = 31'd1257642267;
  localparam logic signed [CW-1:0] KINV_Q30 = 36'sd652032874;
  localparam logic [23:0] DIAM_M = 24'd12742000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    logic       valid;
    logic       vec;
    logic [1:0] tag;
    cval_t      x;
    cval_t      y;
    cval_t      z;
  } cordic_t;

  function automatic cval_t atan_q30(input int i);
    cval_t r;
    case (i)
      0:  r = 36'sd843314857;
      1:  r = 36'sd497837829;
      2:  r = 36'sd263043837;
      3:  r = 36'sd133525159;
      4:  r = 36'sd67021687;
      5:  r = 36'sd33543516;
      6:  r = 36'sd16775851;
      7:  r = 36'sd8388437;
      8:  r = 36'sd4194283;
      9:  r = 36'sd2097149;
      10: r = 36'sd1048576;
      default: begin
        if (i <= 30) r = cval_t'(36'sd1 <<< (30 - i));
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [LatW-1:0] sat_lat(input logic signed [LatW-1:0] v);
    logic signed [LatW-1:0] r;
    if (v > LAT_MAX) r = LatW'(LAT_MAX);
    else if (v < -LAT_MAX) r = LatW'(-LAT_MAX);
    else r = v;
    return r;
  endfunction

  function automatic logic signed [LonW-1:0] sat_lon(input logic signed [LonW-1:0] v);
    logic signed [LonW-1:0] r;
    if (v > LON_MAX) r = LonW'(LON_MAX);
    else if (v < -LON_MAX) r = LonW'(-LON_MAX);
    else r = v;
    return r;
  endfunction

endpackage

/* sv/gcs_if.sv */
`timescale 1ns / 1ps
// handshake channels of the scan: point words, result words, config writes
// depends on gcs_pkg
interface gcs_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gcs_pkg::LatW-1:0]      point_lat;
  logic signed [gcs_pkg::LonW-1:0]      point_lon;
  logic                                 point_ok;
  logic                                 last_point;
  modport source (output valid, point_lat, point_lon, point_ok, last_point, input ready);
  modport sink   (input valid, point_lat, point_lon, point_ok, last_point, output ready);
endinterface

interface gcs_result_if;
  logic                          valid;
  logic                          ready;
  logic [gcs_pkg::DistW-1:0]     distance_m;
  logic                          within_radius;
  logic [gcs_pkg::NumW-1:0]      point_number;
  logic                          scan_done;
  logic                          nearest_found;
  logic [gcs_pkg::NumW-1:0]      nearest_number;
  logic [gcs_pkg::DistW-1:0]     nearest_distance_m;
  modport source (output valid, distance_m, within_radius, point_number, scan_done,
                  nearest_found, nearest_number, nearest_distance_m, input ready);
  modport sink   (input valid, distance_m, within_radius, point_number, scan_done,
                  nearest_found, nearest_number, nearest_distance_m, output ready);
endinterface

interface gcs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gcs_pkg::CfgIdxW-1:0]      index;
  logic [gcs_pkg::CfgDataW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/gcs_cordic_cell.sv */
`timescale 1ns / 1ps
// one cordic micro-rotation, rotation or vectoring mode, registered
// depends on gcs_pkg
module gcs_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcs_pkg::cordic_t    d_i,
  output gcs_pkg::cordic_t    q_o
);
  import gcs_pkg::*;

  cval_t   dx, dy, ang;
  logic    fwd;
  cordic_t q_d, q_q;

  always_comb begin
    dx  = d_i.y >>> IDX;
    dy  = d_i.x >>> IDX;
    ang = atan_q30(IDX);
    // vectoring drives y toward zero, rotation drives z toward zero
    fwd = d_i.vec ? d_i.y[CW-1] : ~d_i.z[CW-1];
    q_d = d_i;
    if (fwd) begin
      q_d.x = d_i.x - dx;
      q_d.y = d_i.y + dy;
      q_d.z = d_i.z - ang;
    end else begin
      q_d.x = d_i.x + dx;
      q_d.y = d_i.y - dy;
      q_d.z = d_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;
endmodule

/* sv/gcs_cordic_chain.sv */
`timescale 1ns / 1ps
// row of registered cordic cells, one micro-rotation per cell
// depends on gcs_pkg, gcs_cordic_cell
module gcs_cordic_chain #(
  parameter int STEPS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcs_pkg::cordic_t    d_i,
  output gcs_pkg::cordic_t    q_o
);
  import gcs_pkg::*;

  cordic_t link [STEPS+1];

  assign link[0] = d_i;

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    gcs_cordic_cell #(.IDX(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .d_i   (link[g]),
      .q_o   (link[g+1])
    );
  end

  assign q_o = link[STEPS];
endmodule

/* sv/gcs_isqrt.sv */
`timescale 1ns / 1ps
// integer square root, one digit per cycle
// depends on gcs_pkg
module gcs_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gcs_pkg::SqW-1:0]   n_i,
  output logic                      done_o,
  output logic [30:0]               root_o
);
  import gcs_pkg::*;

  logic           busy_q;
  logic [SqW:0]   rem_q, rem_d;
  logic [SqW:0]   root_q, root_d;
  logic [SqW-1:0] bit_q;
  logic [SqW:0]   trial;
  logic           ge;

  always_comb begin
    trial  = root_q + {1'b0, bit_q};
    ge     = rem_q >= trial;
    rem_d  = rem_q;
    root_d = root_q >> 1;
    if (ge) begin
      rem_d  = rem_q - trial;
      root_d = (root_q >> 1) + {1'b0, bit_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, n_i};
      root_q <= '0;
      bit_q  <= {1'b1, {(SqW-1){1'b0}}};
    end else if (busy_q) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      bit_q  <= bit_q >> 2;
    end
  end

  assign done_o = busy_q & bit_q[0];
  assign root_o = root_d[30:0];
endmodule

/* sv/great_circle_nearest_and_radius_scan_top.sv */
`timescale 1ns / 1ps
// channel   dir  handshake     word
// point_i   in   valid/ready   point_lat, point_lon, point_ok, last_point
// result_o  out  valid/ready   distance, radius flag, numbers, nearest report
// cfg_i     in   valid/ready   register index, write data (always ready)
// a usable point passes from accept to result through 4 angle conversions,
// the sin/cos cell row, 4 products, 31 root digits, the atan cell row again
// and the metre scaling. a skipped point goes straight to the result stage.
// one point is in work at a time; the result register frees the input side
// unless an earlier word is still waiting there. reset clears the scan state
// and the query registers to zero.
// depends on gcs_pkg, gcs_if, gcs_cordic_chain, gcs_isqrt
module great_circle_nearest_and_radius_scan_top #(
  parameter int MAX_POINTS   = 65536,
  parameter int CORDIC_STEPS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gcs_point_if.sink    point_i,
  gcs_result_if.source result_o,
  gcs_cfg_if.sink      cfg_i
);
  import gcs_pkg::*;

  localparam int PW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_POINTS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CONV  = 4'd1;
  localparam logic [3:0] S_ROT   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_HSUM  = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_VEC   = 4'd6;
  localparam logic [3:0] S_METRE = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  // config registers
  logic signed [LatW-1:0] qlat_q;
  logic signed [LonW-1:0] qlon_q;
  logic [DistW-1:0]       radius_q;

  // scan state
  logic [PW-1:0]    pos_q;
  logic [DistW-1:0] best_q;
  logic [PW-1:0]    best_pos_q;
  logic             any_q;

  // per-point work registers
  logic signed [LatW-1:0] plat_q;
  logic signed [29:0]     dlat_q, dlon_q;
  logic                   ok_q, last_q;
  logic signed [MW-1:0]   s1_q, s2_q, c1_q, c2_q, a1_q, t_q, u_q, b_q;
  logic [CW-2:0]          zpos_q;
  logic [DistW-1:0]       dist_q;

  cordic_t feed_d, feed_q, chain_out;

  // output register
  logic             res_valid_q;
  logic [DistW-1:0] o_dist_q, o_near_dist_q;
  logic             o_within_q, o_done_q, o_found_q;
  logic [NumW-1:0]  o_num_q, o_near_num_q;

  logic in_acc, fin_go;
  assign point_i.ready = (state_q == S_IDLE);
  assign in_acc        = point_i.valid & point_i.ready;
  assign cfg_i.ready   = 1'b1;

  // accept-time differences
  logic signed [LatW-1:0] in_lat;
  logic signed [LonW-1:0] in_lon;
  logic signed [29:0]     dlat_in, dlon_raw, dlon_in;
  always_comb begin
    in_lat   = sat_lat(point_i.point_lat);
    in_lon   = sat_lon(point_i.point_lon);
    dlat_in  = 30'(in_lat) - 30'(qlat_q);
    dlon_raw = 30'(in_lon) - 30'(qlon_q);
    dlon_in  = dlon_raw;
    if (dlon_raw > LON_MAX) dlon_in = dlon_raw - 30'sd360000000;
    else if (dlon_raw < -LON_MAX) dlon_in = dlon_raw + 30'sd360000000;
  end

  // microdegrees to q30 radians
  logic signed [29:0] udeg;
  logic               half;
  logic [29:0]        mag;
  logic [63:0]        cprod, crnd;
  logic [CW-1:0]      rmag;
  cval_t              rad;
  always_comb begin
    case (cnt_q)
      2'd0: begin udeg = dlat_q;         half = 1'b1; end
      2'd1: begin udeg = dlon_q;         half = 1'b1; end
      2'd2: begin udeg = 30'(qlat_q);    half = 1'b0; end
      default: begin udeg = 30'(plat_q); half = 1'b0; end
    endcase
    mag   = udeg[29] ? 30'(-udeg) : 30'(udeg);
    cprod = 64'(mag) * 64'(CONV_Q56);
    if (half) begin
      crnd = (cprod + (64'd1 << 26)) >> 27;
    end else begin
      crnd = (cprod + (64'd1 << 25)) >> 26;
    end
    rmag = crnd[CW-1:0];
    rad  = udeg[29] ? -cval_t'(rmag) : cval_t'(rmag);
  end

  // shared product unit
  logic signed [MW-1:0]     ma, mb, prnd;
  logic signed [2*MW-1:0]   prod;
  always_comb begin
    case (cnt_q)
      2'd0: begin ma = s1_q; mb = s1_q; end
      2'd1: begin ma = c1_q; mb = c2_q; end
      2'd2: begin ma = s2_q; mb = s2_q; end
      default: begin ma = t_q; mb = u_q; end
    endcase
    prod = ma * mb;
    prnd = MW'((prod + (66'sd1 <<< 29)) >>> 30);
  end

  // haversine term and root operands
  logic signed [MW:0] hsum;
  logic [30:0]        h;
  logic [SqW-1:0]     n_cos, n_sin;
  always_comb begin
    hsum = (MW+1)'(a1_q) + (MW+1)'(b_q);
    if (hsum[MW]) h = '0;
    else if (hsum > (MW+1)'(ONE_Q30)) h = ONE_Q30;
    else h = hsum[30:0];
    n_cos = SqW'(ONE_Q30 - h) << 30;
    n_sin = SqW'(h) << 30;
  end

  logic        sq_start, sq_done_a, sq_done_b;
  logic [30:0] root_a, root_b;
  assign sq_start = (state_q == S_HSUM);

  gcs_isqrt u_sqrt_cos (
    .clk_i (clk_i), .rst_ni(rst_ni), .start_i(sq_start), .n_i(n_cos),
    .done_o(sq_done_a), .root_o(root_a)
  );
  gcs_isqrt u_sqrt_sin (
    .clk_i (clk_i), .rst_ni(rst_ni), .start_i(sq_start), .n_i(n_sin),
    .done_o(sq_done_b), .root_o(root_b)
  );

  gcs_cordic_chain #(.STEPS(CORDIC_STEPS)) u_chain (
    .clk_i (clk_i), .rst_ni(rst_ni), .d_i(feed_q), .q_o(chain_out)
  );

  // metre scaling
  logic [58:0]      mprod, mrnd;
  logic [DistW-1:0] metres;
  always_comb begin
    mprod  = 59'(DIAM_M) * 59'(zpos_q);
    mrnd   = (mprod + (59'd1 << 29)) >> 30;
    metres = (mrnd > 59'({DistW{1'b1}})) ? {DistW{1'b1}} : mrnd[DistW-1:0];
  end

  // nearest tracking on the finished point
  logic             take;
  logic             any_n;
  logic [DistW-1:0] best_n;
  logic [PW-1:0]    best_pos_n;
  always_comb begin
    take       = ok_q & (~any_q | (dist_q < best_q));
    any_n      = any_q | ok_q;
    best_n     = take ? dist_q : best_q;
    best_pos_n = take ? pos_q : best_pos_q;
  end

  assign fin_go = (state_q == S_FIN) & (~res_valid_q | result_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    feed_d  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d   = '0;
          state_d = point_i.point_ok ? S_CONV : S_FIN;
        end
      end
      S_CONV: begin
        feed_d.valid = 1'b1;
        feed_d.vec   = 1'b0;
        feed_d.tag   = cnt_q;
        feed_d.x     = KINV_Q30;
        feed_d.y     = '0;
        feed_d.z     = rad;
        cnt_d        = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = S_ROT;
      end
      S_ROT: begin
        if (chain_out.valid && chain_out.tag == 2'd3) begin
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = S_HSUM;
      end
      S_HSUM: state_d = S_SQRT;
      S_SQRT: begin
        if (sq_done_a && sq_done_b) begin
          feed_d.valid = 1'b1;
          feed_d.vec   = 1'b1;
          feed_d.x     = cval_t'(root_a);
          feed_d.y     = cval_t'(root_b);
          feed_d.z     = '0;
          state_d      = S_VEC;
        end
      end
      S_VEC: begin
        if (chain_out.valid) state_d = S_METRE;
      end
      S_METRE: state_d = S_FIN;
      S_FIN: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      feed_q      <= '0;
      qlat_q      <= '0;
      qlon_q      <= '0;
      radius_q    <= '0;
      pos_q       <= '0;
      best_q      <= '0;
      best_pos_q  <= '0;
      any_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      feed_q       <= feed_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_QUERY_LAT: qlat_q   <= sat_lat(cfg_i.data[LatW-1:0]);
          CFG_QUERY_LON: qlon_q   <= sat_lon(cfg_i.data[LonW-1:0]);
          CFG_RADIUS:    radius_q <= cfg_i.data[DistW-1:0];
          default: ;
        endcase
      end
      if (result_o.ready && !fin_go) res_valid_q <= 1'b0;
      if (fin_go) begin
        res_valid_q <= 1'b1;
        best_q      <= best_n;
        best_pos_q  <= best_pos_n;
        if (last_q) begin
          any_q <= 1'b0;
          pos_q <= '0;
        end else begin
          any_q <= any_n;
          pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      plat_q <= in_lat;
      dlat_q <= dlat_in;
      dlon_q <= dlon_in;
      ok_q   <= point_i.point_ok;
      last_q <= point_i.last_point;
      dist_q <= '0;
    end
    if (state_q == S_ROT && chain_out.valid) begin
      case (chain_out.tag)
        2'd0: s1_q <= MW'(chain_out.y);
        2'd1: s2_q <= MW'(chain_out.y);
        2'd2: c1_q <= MW'(chain_out.x);
        default: c2_q <= MW'(chain_out.x);
      endcase
    end
    if (state_q == S_MUL) begin
      case (cnt_q)
        2'd0: a1_q <= prnd;
        2'd1: t_q  <= prnd;
        2'd2: u_q  <= prnd;
        default: b_q <= prnd;
      endcase
    end
    if (state_q == S_VEC && chain_out.valid) begin
      zpos_q <= chain_out.z[CW-1] ? '0 : chain_out.z[CW-2:0];
    end
    if (state_q == S_METRE) dist_q <= metres;
    if (fin_go) begin
      o_dist_q      <= dist_q;
      o_within_q    <= ok_q & (dist_q <= radius_q);
      o_num_q       <= NumW'(pos_q);
      o_done_q      <= last_q;
      o_found_q     <= last_q & any_n;
      o_near_num_q  <= (last_q & any_n) ? NumW'(best_pos_n) : '0;
      o_near_dist_q <= (last_q & any_n) ? best_n : '0;
    end
  end

  assign result_o.valid              = res_valid_q;
  assign result_o.distance_m         = o_dist_q;
  assign result_o.within_radius      = o_within_q;
  assign result_o.point_number       = o_num_q;
  assign result_o.scan_done          = o_done_q;
  assign result_o.nearest_found      = o_found_q;
  assign result_o.nearest_number     = o_near_num_q;
  assign result_o.nearest_distance_m = o_near_dist_q;
endmodule

/* sv/gcs_checker.sv */
`timescale 1ns / 1ps
// port-level checks on the result channel of the scan, bound to the top level
// depends on gcs_pkg, great_circle_nearest_and_radius_scan_top
module gcs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [gcs_pkg::DistW-1:0]   distance_m,
  input logic                        within_radius,
  input logic [gcs_pkg::NumW-1:0]    point_number,
  input logic                        scan_done,
  input logic                        nearest_found,
  input logic [gcs_pkg::NumW-1:0]    nearest_number,
  input logic [gcs_pkg::DistW-1:0]   nearest_distance_m
);
  import gcs_pkg::*;

  logic out_acc;
  logic restart_q;
  assign out_acc = res_valid & res_ready;

  // after a word that closes a scan the next word opens a new one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= 1'b1;
    end else if (out_acc) begin
      restart_q <= scan_done;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(distance_m))
    else $error("result word dropped or changed while stalled");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !scan_done |->
      !nearest_found && nearest_number == '0 && nearest_distance_m == '0)
    else $error("nearest report outside end of scan");

  a_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && scan_done && within_radius |->
      nearest_found && nearest_distance_m <= distance_m)
    else $error("nearest distance above a valid last point");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && restart_q |-> point_number == '0)
    else $error("scan does not restart at position zero");
endmodule

bind great_circle_nearest_and_radius_scan_top gcs_checker u_gcs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid         (result_o.valid),
  .res_ready         (result_o.ready),
  .distance_m        (result_o.distance_m),
  .within_radius     (result_o.within_radius),
  .point_number      (result_o.point_number),
  .scan_done         (result_o.scan_done),
  .nearest_found     (result_o.nearest_found),
  .nearest_number    (result_o.nearest_number),
  .nearest_distance_m(result_o.nearest_distance_m)
);

/* test/great_circle_nearest_and_radius_scan_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the great-circle scan: watches point, result and config channels,
// predicts each result word and compares it. depends on gcs_pkg and gcs_if
module great_circle_nearest_and_radius_scan_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  gcs_point_if   point_w,
  gcs_result_if  result_w,
  gcs_cfg_if     cfg_w,
  output int     errors_o,
  output int     pending_o
);
  import gcs_pkg::*;

  localparam int      Steps   = 32;
  localparam longint  OneQ30  = 64'sd1073741824;
  localparam longint  DistMax = 64'sd33554431;

  typedef struct {
    logic [DistW-1:0] distance_m;
    logic             within_radius;
    logic [NumW-1:0]  point_number;
    logic             scan_done;
    logic             nearest_found;
    logic [NumW-1:0]  nearest_number;
    logic [DistW-1:0] nearest_distance_m;
  } scan_result_t;

  scan_result_t expected_results[$];

  longint          q_lat, q_lon, radius;
  logic [NumW-1:0] position, best_pos;
  longint          best_dist;
  logic            seen_valid;

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint arctan_step(int i);
    longint heads[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return heads[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  // microdegrees to Q30 radians, rounding on the magnitude
  function automatic longint udeg_to_rad(longint u, int sh);
    longint unsigned m, r;
    m = (u < 0) ? -u : u;
    r = (m * 64'd1257642267 + (64'd1 << (sh - 1))) >> sh;
    return (u < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void sincos(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint angle_of(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint haversine_metres(longint plat, longint plon);
    longint dlat, dlon, c1, c2, s1, s2, unused, h, z, d;
    dlat = plat - q_lat;
    dlon = plon - q_lon;
    if (dlon > 180000000) dlon -= 360000000;
    if (dlon < -180000000) dlon += 360000000;
    sincos(udeg_to_rad(dlat, 27), unused, s1);
    sincos(udeg_to_rad(dlon, 27), unused, s2);
    sincos(udeg_to_rad(q_lat, 26), c1, unused);
    sincos(udeg_to_rad(plat, 26), c2, unused);
    h = mul_q30(s1, s1) + mul_q30(mul_q30(c1, c2), mul_q30(s2, s2));
    if (h < 0) h = 0;
    if (h > OneQ30) h = OneQ30;
    z = angle_of(longint'(int_sqrt(longint'(OneQ30 - h) << 30)),
                 longint'(int_sqrt(h << 30)));
    if (z < 0) z = 0;
    d = (64'sd12742000 * z + (64'sd1 <<< 29)) >>> 30;
    if (d > DistMax) d = DistMax;
    return d;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t e, a;
    longint plat, plon, d;
    if (!rst_ni) begin
      q_lat = 0; q_lon = 0; radius = 0;
      position = '0; best_pos = '0; best_dist = 0; seen_valid = 1'b0;
      errors_o = 0;
      expected_results.delete();
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          CFG_QUERY_LAT: q_lat = clamp(longint'($signed(cfg_w.data[LatW-1:0])), LAT_MAX);
          CFG_QUERY_LON: q_lon = clamp(longint'($signed(cfg_w.data[LonW-1:0])), LON_MAX);
          CFG_RADIUS:    radius = longint'(cfg_w.data[DistW-1:0]);
          default: ;
        endcase
      end
      if (point_w.valid && point_w.ready) begin
        plat = clamp(longint'(point_w.point_lat), LAT_MAX);
        plon = clamp(longint'(point_w.point_lon), LON_MAX);
        d = 0;
        if (point_w.point_ok) begin
          d = haversine_metres(plat, plon);
          if (!seen_valid || d < best_dist) begin
            seen_valid = 1'b1;
            best_dist = d;
            best_pos = position;
          end
        end
        e.distance_m         = DistW'(d);
        e.within_radius      = point_w.point_ok && d <= radius;
        e.point_number       = position;
        e.scan_done          = point_w.last_point;
        e.nearest_found      = point_w.last_point && seen_valid;
        e.nearest_number     = e.nearest_found ? best_pos : '0;
        e.nearest_distance_m = e.nearest_found ? DistW'(best_dist) : '0;
        expected_results = {expected_results, e};
        if (point_w.last_point) begin
          position = '0;
          seen_valid = 1'b0;
        end else begin
          position = position + 1'b1;
        end
      end
      if (result_w.valid && result_w.ready) begin
        a.distance_m         = result_w.distance_m;
        a.within_radius      = result_w.within_radius;
        a.point_number       = result_w.point_number;
        a.scan_done          = result_w.scan_done;
        a.nearest_found      = result_w.nearest_found;
        a.nearest_number     = result_w.nearest_number;
        a.nearest_distance_m = result_w.nearest_distance_m;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, actual dist=%0d num=%0d", $time,
                   a.distance_m, a.point_number);
          errors_o++;
        end else begin
          e = expected_results.pop_front();
          if (a.distance_m !== e.distance_m) begin
            $display("%0t: distance_m expected %0d actual %0d", $time,
                     e.distance_m, a.distance_m);
            errors_o++;
          end
          if (a.within_radius !== e.within_radius) begin
            $display("%0t: within_radius expected %0d actual %0d", $time,
                     e.within_radius, a.within_radius);
            errors_o++;
          end
          if (a.point_number !== e.point_number) begin
            $display("%0t: point_number expected %0d actual %0d", $time,
                     e.point_number, a.point_number);
            errors_o++;
          end
          if (a.scan_done !== e.scan_done) begin
            $display("%0t: scan_done expected %0d actual %0d", $time,
                     e.scan_done, a.scan_done);
            errors_o++;
          end
          if (a.nearest_found !== e.nearest_found) begin
            $display("%0t: nearest_found expected %0d actual %0d", $time,
                     e.nearest_found, a.nearest_found);
            errors_o++;
          end
          if (a.nearest_number !== e.nearest_number) begin
            $display("%0t: nearest_number expected %0d actual %0d", $time,
                     e.nearest_number, a.nearest_number);
            errors_o++;
          end
          if (a.nearest_distance_m !== e.nearest_distance_m) begin
            $display("%0t: nearest_distance_m expected %0d actual %0d", $time,
                     e.nearest_distance_m, a.nearest_distance_m);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

/* test/great_circle_nearest_and_radius_scan_top_test.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the great-circle scan: directed points, then random scans
// under several query settings and idle patterns. depends on gcs_pkg, gcs_if, checker
module great_circle_nearest_and_radius_scan_top_test;
  import gcs_pkg::*;

  localparam int  Settle    = 130;
  localparam int  CycleCap  = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  int   tx_idle, rx_idle;
  int   rx_hold;
  int   cycles;

  gcs_point_if  point_ch ();
  gcs_result_if result_ch ();
  gcs_cfg_if    cfg_ch ();

  great_circle_nearest_and_radius_scan_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (point_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  great_circle_nearest_and_radius_scan_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .point_w   (point_ch),
    .result_w  (result_ch),
    .cfg_w     (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure, long hold counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_ch.ready = 1'b0;
    end else if (rx_hold > 0) begin
      result_ch.ready = 1'b0;
      rx_hold--;
    end else begin
      result_ch.ready = ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_point(logic [LatW-1:0] lat, logic [LonW-1:0] lon, logic ok,
                            logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      point_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    point_ch.valid      = 1'b1;
    point_ch.point_lat  = lat;
    point_ch.point_lon  = lon;
    point_ch.point_ok   = ok;
    point_ch.last_point = last;
    @(posedge clk_i);
    while (!point_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    point_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic set_query(logic [CfgDataW-1:0] lat, logic [CfgDataW-1:0] lon,
                           logic [CfgDataW-1:0] rad);
    write_reg(CFG_QUERY_LAT, lat);
    write_reg(CFG_QUERY_LON, lon);
    write_reg(CFG_RADIUS, rad);
  endtask

  function automatic logic [LatW-1:0] rand_lat();
    if ($urandom_range(9) == 0) return LatW'($urandom);
    return LatW'($signed($urandom_range(180000000)) - 90000000);
  endfunction

  function automatic logic [LonW-1:0] rand_lon();
    if ($urandom_range(9) == 0) return LonW'($urandom);
    return LonW'($signed($urandom_range(360000000)) - 180000000);
  endfunction

  // random scans of short length, mostly usable points
  task automatic random_scans(int count, bit with_hold);
    int len;
    int sent;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        send_point(rand_lat(), rand_lon(), $urandom_range(99) < 85, k == len - 1);
        sent++;
        if (with_hold && sent == 40) rx_hold = 600;
      end
    end
  endtask

  initial begin
    point_ch.valid = 1'b0;
    point_ch.point_lat = '0;
    point_ch.point_lon = '0;
    point_ch.point_ok = 1'b0;
    point_ch.last_point = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    result_ch.ready = 1'b0;
    tx_idle = 0;
    rx_idle = 0;
    rx_hold = 0;
    cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: query at origin, widest radius
    set_query(32'd0, 32'd0, 32'd20015087);
    send_point(LatW'(0), LonW'(0), 1'b1, 1'b0);                      // zero distance
    send_point(LatW'(90000000), LonW'(180000000), 1'b1, 1'b0);
    send_point(LatW'(-90000000), LonW'(-180000000), 1'b1, 1'b0);
    send_point(LatW'(0), LonW'(180000000), 1'b1, 1'b0);              // antipode
    send_point(LatW'(0), LonW'(-180000000), 1'b1, 1'b0);
    send_point(28'h7ff_ffff, 29'h0fff_ffff, 1'b1, 1'b0);             // above range
    send_point(28'h800_0000, 29'h1000_0000, 1'b1, 1'b0);             // below range
    send_point(28'hfff_ffff, 29'h1fff_ffff, 1'b0, 1'b0);             // skipped
    send_point(LatW'(0), LonW'(0), 1'b1, 1'b1);                      // tie, first wins
    send_point(LatW'(1000), LonW'(2000), 1'b0, 1'b1);                // nothing usable
    send_point(LatW'(45000000), LonW'(90000000), 1'b1, 1'b1);        // one-point scan
    drain();
    // longitude wrap across the date line, radius zero
    set_query(32'd90000000, 32'hf546_0f80, 32'd0);                   // -179957888
    send_point(LatW'(90000000), LonW'(-180000000), 1'b1, 1'b0);
    send_point(LatW'(-10000000), LonW'(179999999), 1'b1, 1'b0);
    send_point(LatW'(-90000000), LonW'(0), 1'b1, 1'b0);
    send_point(LatW'(12345678), LonW'(-1), 1'b1, 1'b1);
    drain();

    // out-of-range query, all-ones radius
    tx_idle = 19; rx_idle = 51;
    set_query(32'hf800_0000, 32'h0fff_ffff, 32'hffff_ffff);
    random_scans(210, 1'b1);
    drain();

    tx_idle = 51; rx_idle = 19;
    set_query({4'($urandom_range(15)),
               LatW'($signed($urandom_range(180000000)) - 90000000)},
              {3'($urandom_range(7)),
               LonW'($signed($urandom_range(360000000)) - 180000000)},
              $urandom_range(20015087));
    random_scans(210, 1'b0);
    drain();

    tx_idle = 0; rx_idle = 0;
    set_query($urandom, $urandom, $urandom_range(8000000));
    random_scans(210, 1'b0);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
